### sv/dpd_pkg.sv
// Shared types and constants for the debug packet deframer.
// Used by dpd_front, dpd_queue, dpd_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

    // Internal length counter width; lengths saturate at its maximum.
    localparam int LENGTH_WIDTH = 16;

    // Queue between the front and the back part.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_END     = 2'd2,
        KIND_BAD_HDR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [6:0]  repeat_count;
        logic        checksum_ok;
        logic [15:0] payload_length;
    } t_result;

    // All results caused by one received byte: up to two.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_bundle;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

### sv/debug_packet_deframer_unit.sv
// Debug packet deframer: takes one received serial byte per transaction and reports
// payload data, restarts, packet ends and bad notification headers. Needs dpd_pkg,
// dpd_front, dpd_queue and dpd_back.
//
// The block accepts one byte every cycle as long as each byte causes at most one
// result and i_stall stays low; the output register hands out one result per cycle
// while i_stall is low, so bytes that cause two results can fill the queue. A
// four-entry bundle queue sits between the byte decoder and the output stage, so
// input stalls only when that queue is full. A result passes through that queue and
// then the output register before it is valid at the output. All results of one
// byte come out back to back, the final one flagged by o_last_of_input.
`timescale 1ns / 1ps
`default_nettype none

module debug_packet_deframer_unit import dpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [6:0]       o_repeat_count,
    output logic             o_checksum_ok,
    output logic [15:0]      o_payload_length,
    output logic             o_last_of_input
);

    t_bundle   front_bundle;
    logic      push;
    logic      pop;
    t_bundle   head;
    t_q_status q_status;
    t_result   result;
    logic      accept;

    assign o_stall = q_status.full;
    assign accept  = i_valid && !q_status.full;

    dpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_bundle  (front_bundle),
        .o_push    (push)
    );

    dpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (front_bundle),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    dpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (result),
        .o_last   (o_last_of_input)
    );

    assign o_kind           = result.kind;
    assign o_data_byte      = result.data_byte;
    assign o_repeat_count   = result.repeat_count;
    assign o_checksum_ok    = result.checksum_ok;
    assign o_payload_length = result.payload_length;

endmodule

`default_nettype wire

### sv/dpd_front.sv
// Front part of the debug packet deframer: accepts received bytes, tracks framing
// state and builds the result bundle for each byte. Depends on dpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpd_front import dpd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    output t_bundle         o_bundle,
    output logic            o_push
);

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_BODY = 6'b000010,
        PH_HEAD = 6'b000100,
        PH_RLE  = 6'b001000,
        PH_CKH  = 6'b010000,
        PH_CKL  = 6'b100000
    } t_phase;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BRACE   = 8'h7D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] ESC_MASK   = 8'h20;
    localparam logic [7:0] RLE_BASE   = 8'd29;
    localparam logic [7:0] RLE_TOP    = 8'd126;
    localparam logic [2:0] HDR_LAST   = 3'd4;

    function automatic logic [7:0] stop_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h53;  // S
            3'd1:    return 8'h74;  // t
            3'd2:    return 8'h6F;  // o
            3'd3:    return 8'h70;  // p
            3'd4:    return 8'h3A;  // :
            default: return 8'h53;
        endcase
    endfunction

    // Bit 4 flags a character that is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        if (ch inside {[CH_0:CH_9]}) return 5'(ch - CH_0);
        if (ch inside {[CH_UA:CH_UF]}) return 5'(ch - CH_UA + 8'd10);
        if (ch inside {[CH_LA:CH_LF]}) return 5'(ch - CH_LA + 8'd10);
        return 5'h10;
    endfunction

    function automatic logic [LENGTH_WIDTH-1:0] sat_add(input logic [LENGTH_WIDTH-1:0] len,
                                                        input logic [6:0] k);
        logic [LENGTH_WIDTH:0] s;
        s = {1'b0, len} + (LENGTH_WIDTH + 1)'(k);
        if (s[LENGTH_WIDTH]) return '1;
        return s[LENGTH_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] len_report(input logic [LENGTH_WIDTH-1:0] len);
        logic [LENGTH_WIDTH+16:0] wide;
        wide = (LENGTH_WIDTH + 17)'(len);
        if (wide > (LENGTH_WIDTH + 17)'(16'hFFFF)) return 16'hFFFF;
        return wide[15:0];
    endfunction

    function automatic t_bundle put(input t_bundle b, input t_result r);
        t_bundle nb;
        nb = b;
        if (b.cnt == 2'd0) nb.res0 = r;
        else nb.res1 = r;
        nb.cnt = b.cnt + 2'd1;
        return nb;
    endfunction

    function automatic t_result mk_res(input t_kind kind, input logic [7:0] data,
                                       input logic [6:0] rep, input logic ok,
                                       input logic [15:0] len);
        t_result r;
        r.kind           = kind;
        r.data_byte      = data;
        r.repeat_count   = rep;
        r.checksum_ok    = ok;
        r.payload_length = len;
        return r;
    endfunction

    t_phase                  r_phase, n_phase;
    logic [7:0]              r_sum, n_sum;
    logic                    r_esc, n_esc;
    logic [7:0]              r_prev, n_prev;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [2:0]              r_hidx, n_hidx;
    logic                    r_hmatch, n_hmatch;
    logic [4:0]              r_ckh, n_ckh;

    t_bundle    bundle;
    logic       do_body;
    logic       do_lit;
    logic [7:0] lit;
    logic [4:0] lo;
    logic       ok;
    logic [6:0] rle_cnt;
    logic [7:0] c;

    assign c = i_rx_byte;

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_esc    = r_esc;
        n_prev   = r_prev;
        n_len    = r_len;
        n_hidx   = r_hidx;
        n_hmatch = r_hmatch;
        n_ckh    = r_ckh;
        bundle   = '0;
        do_body  = 1'b0;
        do_lit   = 1'b0;
        lit      = '0;
        lo       = hex_val(c);
        ok       = 1'b0;
        rle_cnt  = 7'(c - RLE_BASE);

        case (r_phase)
            PH_BODY: begin
                do_body = 1'b1;
            end
            PH_HEAD: begin
                n_sum = r_sum + c;
                if (c != stop_char(r_hidx)) n_hmatch = 1'b0;
                if (r_hidx == HDR_LAST) begin
                    n_hidx = '0;
                    if (n_hmatch) begin
                        n_phase = PH_BODY;
                    end else begin
                        n_phase = PH_HUNT;
                        bundle  = put(bundle, mk_res(KIND_BAD_HDR, '0, '0, 1'b0, '0));
                    end
                    n_hmatch = 1'b1;
                end else begin
                    n_hidx = r_hidx + 3'd1;
                end
            end
            PH_RLE: begin
                n_phase = PH_BODY;
                if (c inside {[RLE_BASE:RLE_TOP]} && c != CH_DOLLAR && c != CH_HASH) begin
                    n_sum = r_sum + c;
                    n_len = sat_add(r_len, rle_cnt);
                    if (rle_cnt != '0)
                        bundle = put(bundle, mk_res(KIND_DATA, r_prev, rle_cnt, 1'b0, '0));
                end else begin
                    // Bad count: the star stands as a plain byte, then reprocess this byte.
                    lit    = CH_STAR ^ (r_esc ? ESC_MASK : 8'h00);
                    n_esc  = 1'b0;
                    n_prev = lit;
                    n_len  = sat_add(r_len, 7'd1);
                    bundle = put(bundle, mk_res(KIND_DATA, lit, 7'd1, 1'b0, '0));
                    do_body = 1'b1;
                end
            end
            PH_CKH: begin
                n_ckh   = lo;
                n_phase = PH_CKL;
            end
            PH_CKL: begin
                ok = !r_ckh[4] && !lo[4] && ({r_ckh[3:0], lo[3:0]} == r_sum);
                bundle  = put(bundle, mk_res(KIND_END, '0, '0, ok, len_report(r_len)));
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
                if (c == CH_DOLLAR || c == CH_PERCENT) do_body = 1'b1;
            end
        endcase

        if (do_body) begin
            case (c)
                CH_DOLLAR: begin
                    n_len   = '0;
                    n_sum   = '0;
                    n_esc   = 1'b0;
                    n_phase = PH_BODY;
                    bundle  = put(bundle, mk_res(KIND_RESTART, '0, '0, 1'b0, '0));
                end
                CH_PERCENT: begin
                    n_len    = '0;
                    n_sum    = '0;
                    n_esc    = 1'b0;
                    n_phase  = PH_HEAD;
                    n_hidx   = '0;
                    n_hmatch = 1'b1;
                    bundle   = put(bundle, mk_res(KIND_RESTART, '0, '0, 1'b0, '0));
                end
                CH_HASH: begin
                    n_phase = PH_CKH;
                end
                CH_BRACE: begin
                    n_sum = n_sum + c;
                    n_esc = 1'b1;
                end
                CH_STAR: begin
                    n_sum = n_sum + c;
                    if (n_len != '0) n_phase = PH_RLE;
                    else do_lit = 1'b1;
                end
                default: begin
                    n_sum  = n_sum + c;
                    do_lit = 1'b1;
                end
            endcase
        end

        if (do_lit) begin
            lit    = c ^ (n_esc ? ESC_MASK : 8'h00);
            n_esc  = 1'b0;
            n_prev = lit;
            n_len  = sat_add(n_len, 7'd1);
            bundle = put(bundle, mk_res(KIND_DATA, lit, 7'd1, 1'b0, '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_sum    <= '0;
            r_esc    <= 1'b0;
            r_prev   <= '0;
            r_len    <= '0;
            r_hidx   <= '0;
            r_hmatch <= 1'b1;
            r_ckh    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_esc    <= n_esc;
            r_prev   <= n_prev;
            r_len    <= n_len;
            r_hidx   <= n_hidx;
            r_hmatch <= n_hmatch;
            r_ckh    <= n_ckh;
        end
    end

    assign o_bundle = bundle;
    assign o_push   = i_accept && (bundle.cnt != 2'd0);

endmodule

`default_nettype wire

### sv/dpd_queue.sv
// Short queue of result bundles between the front and the back part.
// Depends on dpd_pkg for the bundle type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dpd_queue import dpd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_push_data,
    input  wire logic    i_pop,
    output t_bundle      o_head,
    output t_q_status    o_status
);

    t_bundle              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + Q_CNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - Q_CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (i_pop) r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_data;
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));

endmodule

`default_nettype wire

### sv/dpd_back.sv
// Back part of the debug packet deframer: unpacks queued bundles into single
// results and holds them in the output register. Depends on dpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpd_back import dpd_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_bundle   i_head,
    input  wire t_q_status i_status,
    output logic           o_pop,
    input  wire logic      i_stall,
    output logic           o_valid,
    output t_result        o_result,
    output logic           o_last
);

    logic    r_valid;
    logic    r_sel;
    t_result r_out;
    logic    r_last;

    logic    load;
    logic    take;
    logic    sel_last;

    // Load a new result when the register is empty or its transaction completes.
    assign load     = !r_valid || !i_stall;
    assign take     = load && !i_status.empty;
    assign sel_last = r_sel || (i_head.cnt == 2'd1);
    assign o_pop    = take && sel_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_status.empty;
            if (take) r_sel <= !sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out  <= r_sel ? i_head.res1 : i_head.res0;
            r_last <= sel_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;
    assign o_last   = r_last;

endmodule

`default_nettype wire
